### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FBPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fbpa check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FBPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fbpa check failed");

`endif

### hdl/fbpa_pkg.sv
// Package for the fixed block pool allocator: sizes, codes and shared types.
// No dependencies.
package fbpa_pkg;

    localparam int MAX_PAGES     = 16;
    localparam int MAX_BLOCKS    = 64;
    localparam int POINTER_BYTES = 8;
    localparam int STACK_DEPTH   = 1024;

    localparam int ADDR_W  = 22;
    localparam int REQ_W   = 13;
    localparam int BLKC_W  = 7;
    localparam int SIZE_W  = REQ_W + 1;
    localparam int PAGE_W  = $clog2(MAX_PAGES + 1);
    localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W   = $clog2(MAX_PAGES * MAX_BLOCKS);
    localparam int SPTR_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int PROD_W  = IDX_W + SIZE_W;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_NULL_FREE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUT_OF_PAGES = 2'd2;
    localparam logic [STAT_W-1:0] ST_STACK_FULL   = 2'd3;

    localparam logic REG_BLOCK_BYTES     = 1'b0;
    localparam logic REG_BLOCKS_PER_PAGE = 1'b1;

    localparam logic [REQ_W-1:0]  RST_BLOCK_BYTES = REQ_W'(8);
    localparam logic [BLKC_W-1:0] RST_BLOCKS      = BLKC_W'(64);

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  blocks;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [SPTR_W-1:0] waddr;
        logic [ADDR_W-1:0] wdata;
        logic              re;
        logic [SPTR_W-1:0] raddr;
    } t_mem_req;

endpackage

### hdl/fbpa_stack_ram.sv
// Free stack storage: one write port and one registered read port.
// Depends on fbpa_pkg for depth, widths and the request struct.
module fbpa_stack_ram
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [ADDR_W-1:0] o_rd_data
);

    logic [ADDR_W-1:0] r_mem [STACK_DEPTH];
    logic [ADDR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/fbpa_regs.sv
// APB register file: block size and blocks per page, with derived values.
// Depends on fbpa_pkg for widths, register indexes and t_cfg.
module fbpa_regs
    import fbpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [REQ_W-1:0]  r_block_bytes;
    logic [BLKC_W-1:0] r_blocks;
    logic              wr_en;
    logic [SIZE_W-1:0] req_ext;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= RST_BLOCK_BYTES;
            r_blocks      <= RST_BLOCKS;
        end else if (wr_en) begin
            case (paddr[2])
                REG_BLOCK_BYTES:     r_block_bytes <= pwdata[REQ_W-1:0];
                REG_BLOCKS_PER_PAGE: r_blocks      <= pwdata[BLKC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BLOCK_BYTES:     prdata = PDATA_W'(r_block_bytes);
            REG_BLOCKS_PER_PAGE: prdata = PDATA_W'(r_blocks);
            default:             prdata = '0;
        endcase
    end

    // Round the size up to pointer alignment, never below one pointer.
    assign req_ext = SIZE_W'(r_block_bytes);
    always_comb begin
        if (req_ext < SIZE_W'(POINTER_BYTES)) begin
            o_cfg.size = SIZE_W'(POINTER_BYTES);
        end else begin
            o_cfg.size = (req_ext + SIZE_W'(POINTER_BYTES - 1))
                         & ~SIZE_W'(POINTER_BYTES - 1);
        end
    end

    // Clamp blocks per page to the legal range.
    always_comb begin
        if (r_blocks < BLKC_W'(2)) begin
            o_cfg.blocks = BLK_W'(2);
        end else if (32'(r_blocks) > 32'(MAX_BLOCKS)) begin
            o_cfg.blocks = BLK_W'(MAX_BLOCKS);
        end else begin
            o_cfg.blocks = BLK_W'(r_blocks);
        end
    end

endmodule

### hdl/fbpa_ctrl.sv
// Request sequencer: stack pointer, page counter, page refill and result register.
// Depends on fbpa_pkg; drives the free stack RAM through t_mem_req.
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [ADDR_W-1:0] i_free_address,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ADDR_W-1:0] o_block_address,
    output logic [STAT_W-1:0] o_status,
    output logic [PAGE_W-1:0] o_pages_in_use,
    output t_mem_req          o_mem,
    input  logic [ADDR_W-1:0] i_rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [IDX_W-1:0]  r_base, n_base;
    logic [BLK_W-1:0]  r_slot, n_slot;
    logic [BLK_W-1:0]  r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [STAT_W-1:0] r_status, n_status;
    logic [PAGE_W-1:0] r_opages, n_opages;

    logic              accept;
    logic [CNT_W-1:0]  cnt_dec;
    logic [IDX_W-1:0]  page_base;
    logic [IDX_W-1:0]  fill_idx;
    logic [PROD_W-1:0] fill_prod;
    logic [ADDR_W-1:0] fill_addr;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign cnt_dec    = r_cnt - CNT_W'(1);

    // Block index of slot zero of the page about to open.
    assign page_base  = IDX_W'(r_page) * IDX_W'(i_cfg.blocks);
    assign fill_idx   = r_base + IDX_W'(r_slot);
    assign fill_prod  = PROD_W'(fill_idx) * PROD_W'(i_cfg.size);
    assign fill_addr  = fill_prod[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_page      = r_page;
        n_base      = r_base;
        n_slot      = r_slot;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_addr      = r_addr;
        n_status    = r_status;
        n_opages    = r_opages;
        o_mem       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr   = '0;
                    n_opages = r_page;
                    if (i_req_type == REQ_ALLOC) begin
                        if (r_cnt != '0) begin
                            // Pop: data arrives from the RAM next cycle.
                            n_cnt       = cnt_dec;
                            o_mem.re    = 1'b1;
                            o_mem.raddr = cnt_dec[SPTR_W-1:0];
                            n_state     = S_READ;
                        end else if (32'(r_page) >= 32'(MAX_PAGES)) begin
                            n_status    = ST_OUT_OF_PAGES;
                            n_out_valid = 1'b1;
                        end else begin
                            n_base  = page_base;
                            n_slot  = BLK_W'(1);
                            n_last  = i_cfg.blocks - BLK_W'(1);
                            n_state = S_FILL;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        if (i_free_address == '0) begin
                            n_status = ST_NULL_FREE;
                        end else if (32'(r_cnt) >= 32'(STACK_DEPTH)) begin
                            n_status = ST_STACK_FULL;
                        end else begin
                            n_status    = ST_OK;
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_cnt[SPTR_W-1:0];
                            o_mem.wdata = i_free_address;
                            n_cnt       = r_cnt + CNT_W'(1);
                        end
                    end
                end
            end
            S_READ: begin
                n_addr      = i_rd_data;
                n_status    = ST_OK;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_FILL: begin
                if (r_slot == r_last) begin
                    // Top slot is handed out directly instead of push then pop.
                    n_addr      = fill_addr;
                    n_status    = ST_OK;
                    n_page      = r_page + PAGE_W'(1);
                    n_opages    = r_page + PAGE_W'(1);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_cnt[SPTR_W-1:0];
                    o_mem.wdata = fill_addr;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_slot      = r_slot + BLK_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_page      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_page      <= n_page;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_slot   <= n_slot;
        r_last   <= n_last;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_opages <= n_opages;
    end

    assign o_out_valid     = r_out_valid;
    assign o_block_address = r_addr;
    assign o_status        = r_status;
    assign o_pages_in_use  = r_opages;

endmodule

### hdl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: registers, sequencer, free stack RAM.
// Depends on fbpa_pkg, fbpa_regs, fbpa_ctrl and fbpa_stack_ram.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------------
//  request  | i_in_valid / o_in_ready        | i_req_type, i_free_address
//  result   | o_out_valid / i_out_ready      | o_block_address, o_status, o_pages_in_use
//  config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// Sequence: a free or an out-of-pages allocate has its result registered at the
// accepting edge; a pop reads the stack RAM through its registered read port and
// registers the result from S_READ; opening a page (after clamping) passes the
// accepting step, one RAM write per pushed slot through the single write port,
// and a final step that returns the top slot directly.
// Reset is synchronous, active low; the stack RAM needs no clearing pass.
// A new request is taken while a result waits, as long as it is taken that cycle.
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [ADDR_W-1:0]  i_free_address,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ADDR_W-1:0]  o_block_address,
    output logic [STAT_W-1:0]  o_status,
    output logic [PAGE_W-1:0]  o_pages_in_use,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg              cfg;
    t_mem_req          mem_req;
    logic [ADDR_W-1:0] mem_rd_data;

    // Hold block size and page geometry; derive rounded size and clamped count.
    fbpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequence each request: push, pop, or refill a fresh page.
    fbpa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_free_address  (i_free_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_block_address (o_block_address),
        .o_status        (o_status),
        .o_pages_in_use  (o_pages_in_use),
        .o_mem           (mem_req),
        .i_rd_data       (mem_rd_data)
    );

    // Store free block addresses, LIFO order kept by the sequencer's pointer.
    fbpa_stack_ram u_stack (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

endmodule

### hdl/fbpa_checker.sv
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [ADDR_W-1:0] o_block_address,
    input logic [STAT_W-1:0] o_status,
    input logic [PAGE_W-1:0] o_pages_in_use
);

    // Every error answer carries a null address.
    `FBPA_ASSERT_NOW(a_err_null_addr, o_out_valid && (o_status != ST_OK), o_block_address == '0)

    // Out of pages only once every page has been opened.
    `FBPA_ASSERT_NOW(a_oop_all_pages, o_out_valid && (o_status == ST_OUT_OF_PAGES), 32'(o_pages_in_use) == 32'(MAX_PAGES))

    // The page count never passes its limit.
    `FBPA_ASSERT_NOW(a_pages_bound, o_out_valid, 32'(o_pages_in_use) <= 32'(MAX_PAGES))

    // A stalled result holds its payload.
    `FBPA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_block_address) && $stable(o_status))

    // Take a request only when the result slot is free or draining.
    `FBPA_ASSERT_NOW(a_in_ready_gate, o_in_ready, !o_out_valid || i_out_ready)

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_block_address (o_block_address),
    .o_status        (o_status),
    .o_pages_in_use  (o_pages_in_use)
);
